/* design/mbadu_pkg.sv */
// Package with the shared types, codes and the CRC step of the Modbus ADU frame checker.
package mbadu_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAMING_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_UNIT_ID = 1'b1;

  localparam logic MODE_RTU = 1'b0;
  localparam logic MODE_TCP = 1'b1;

  localparam logic [7:0] MAX_UNIT_ID_RESET = 8'd247;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 9'd511;
  localparam int HEADER_LEN = 7;

  localparam logic [COUNT_W-1:0] RTU_MIN_FRAME = 9'd4;
  localparam logic [COUNT_W-1:0] TCP_MIN_FRAME = 9'd8;
  localparam logic [COUNT_W-1:0] RTU_OVERHEAD = 9'd3;
  localparam logic [COUNT_W-1:0] TCP_OVERHEAD = 9'd7;
  localparam logic [COUNT_W-1:0] RTU_PLEN_SAT = 9'd258;
  localparam logic [COUNT_W-1:0] TCP_PLEN_SAT = 9'd262;
  localparam logic [16:0] MBAP_LEN_OFFSET = 17'd6;
  localparam logic [15:0] MBAP_MIN_LEN = 16'd2;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_BAD_CRC = 2'd2,
    ST_BAD_PROTO = 2'd3
  } status_t;

  typedef struct packed {
    status_t status;
    logic [7:0] unit_id;
    logic [15:0] mbap_tid;
    logic [7:0] payload_len;
  } result_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* design/mbadu_in_if.sv */
// Byte channel into the Modbus ADU frame checker.
interface mbadu_in_if;
  logic valid;
  logic ready;
  logic [7:0] frame_byte;
  logic last_byte;

  modport source(output valid, frame_byte, last_byte, input ready);
  modport sink(input valid, frame_byte, last_byte, output ready);
endinterface

/* design/mbadu_out_if.sv */
// Verdict channel out of the Modbus ADU frame checker.
interface mbadu_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [7:0] unit_id;
  logic [15:0] mbap_tid;
  logic [7:0] payload_len;

  modport source(output valid, status, unit_id, mbap_tid, payload_len, input ready);
  modport sink(input valid, status, unit_id, mbap_tid, payload_len, output ready);
endinterface

/* design/modbus_adu_frame_checker.sv */
// Top level of the Modbus ADU frame checker: per-byte CRC, header capture and frame verdict.
// The last byte of a frame passes the input register, then the verdict register, before its
// verdict is valid. Throughput: one byte per cycle unless a stalled verdict holds a last byte;
// both registers keep the sides moving; the byte-wide CRC step and length checks sit between.
// Reset: synchronous, active high; clears both registers' valid flags, the frame state
// and the configuration (RTU framing, highest unit id 247).
module modbus_adu_frame_checker #(
  parameter int RTU_MAX_FRAME = 256,
  parameter int TCP_MAX_FRAME = 260
) (
  input  logic clk,
  input  logic rst,
  mbadu_in_if.sink frame,
  mbadu_out_if.source verdict,
  input  logic cfg_we,
  input  logic [mbadu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbadu_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [mbadu_pkg::COUNT_W-1:0] RTU_MAX = mbadu_pkg::COUNT_W'(RTU_MAX_FRAME);
  localparam logic [mbadu_pkg::COUNT_W-1:0] TCP_MAX = mbadu_pkg::COUNT_W'(TCP_MAX_FRAME);

  logic framing_mode;
  logic [7:0] max_unit_id;

  logic s1_valid;
  logic [7:0] s1_byte;
  logic s1_last;

  logic [15:0] running_crc;
  logic [7:0] tail_bytes [2];
  logic [mbadu_pkg::COUNT_W-1:0] byte_count;
  logic [7:0] header_bytes [mbadu_pkg::HEADER_LEN];

  logic out_valid;
  mbadu_pkg::result_t result;

  logic out_free;
  logic s1_fire;
  logic [15:0] crc_next;
  logic [mbadu_pkg::COUNT_W-1:0] count_next;
  mbadu_pkg::result_t result_next;
  logic [15:0] rx_crc;
  logic [15:0] proto_id;
  logic [15:0] mbap_len;

  assign out_free = !out_valid || verdict.ready;
  assign s1_fire = s1_valid && (!s1_last || out_free);
  assign frame.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      framing_mode <= mbadu_pkg::MODE_RTU;
      max_unit_id <= mbadu_pkg::MAX_UNIT_ID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mbadu_pkg::CFG_FRAMING_MODE: framing_mode <= cfg_data[0];
        mbadu_pkg::CFG_MAX_UNIT_ID: max_unit_id <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      s1_byte <= frame.frame_byte;
      s1_last <= frame.last_byte;
    end
  end

  always_comb begin
    crc_next = running_crc;
    if (byte_count >= 9'd2) begin
      crc_next = mbadu_pkg::crc_update(running_crc, tail_bytes[0]);
    end
    count_next = (byte_count < mbadu_pkg::COUNT_LIMIT) ? byte_count + 9'd1 : byte_count;
    rx_crc = {s1_byte, tail_bytes[1]};
    proto_id = {header_bytes[2], header_bytes[3]};
    mbap_len = {header_bytes[4], header_bytes[5]};

    result_next = '0;
    result_next.status = mbadu_pkg::ST_OK;
    if (framing_mode == mbadu_pkg::MODE_RTU) begin
      if (count_next < mbadu_pkg::RTU_MIN_FRAME || count_next > RTU_MAX) begin
        result_next.status = mbadu_pkg::ST_MALFORMED;
      end else if (header_bytes[0] > max_unit_id) begin
        result_next.status = mbadu_pkg::ST_MALFORMED;
      end else if (crc_next != rx_crc) begin
        result_next.status = mbadu_pkg::ST_BAD_CRC;
      end else begin
        result_next.unit_id = header_bytes[0];
        result_next.payload_len = (count_next >= mbadu_pkg::RTU_PLEN_SAT) ? 8'hFF :
                                  8'(count_next - mbadu_pkg::RTU_OVERHEAD);
      end
    end else begin
      if (count_next < mbadu_pkg::TCP_MIN_FRAME || count_next > TCP_MAX) begin
        result_next.status = mbadu_pkg::ST_MALFORMED;
      end else if (proto_id != 16'd0) begin
        result_next.status = mbadu_pkg::ST_BAD_PROTO;
      end else if (mbap_len < mbadu_pkg::MBAP_MIN_LEN ||
                   17'(mbap_len) + mbadu_pkg::MBAP_LEN_OFFSET != 17'(count_next) ||
                   header_bytes[6] > max_unit_id) begin
        result_next.status = mbadu_pkg::ST_MALFORMED;
      end else begin
        result_next.unit_id = header_bytes[6];
        result_next.mbap_tid = {header_bytes[0], header_bytes[1]};
        result_next.payload_len = (count_next >= mbadu_pkg::TCP_PLEN_SAT) ? 8'hFF :
                                  8'(count_next - mbadu_pkg::TCP_OVERHEAD);
      end
    end
  end

  // Frame state is restored to its reset values after every last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= mbadu_pkg::CRC_INIT;
      tail_bytes[0] <= '0;
      tail_bytes[1] <= '0;
      byte_count <= '0;
      for (int i = 0; i < mbadu_pkg::HEADER_LEN; i++) begin
        header_bytes[i] <= '0;
      end
    end else if (s1_fire) begin
      if (s1_last) begin
        running_crc <= mbadu_pkg::CRC_INIT;
        tail_bytes[0] <= '0;
        tail_bytes[1] <= '0;
        byte_count <= '0;
        for (int i = 0; i < mbadu_pkg::HEADER_LEN; i++) begin
          header_bytes[i] <= '0;
        end
      end else begin
        running_crc <= crc_next;
        tail_bytes[0] <= tail_bytes[1];
        tail_bytes[1] <= s1_byte;
        byte_count <= count_next;
        for (int i = 0; i < mbadu_pkg::HEADER_LEN; i++) begin
          if (byte_count == mbadu_pkg::COUNT_W'(i)) begin
            header_bytes[i] <= s1_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      result <= result_next;
    end
  end

  assign verdict.valid = out_valid;
  assign verdict.status = result.status;
  assign verdict.unit_id = result.unit_id;
  assign verdict.mbap_tid = result.mbap_tid;
  assign verdict.payload_len = result.payload_len;

endmodule

/* design/mbadu_checker.sv */
// Port-level assertions for the Modbus ADU frame checker and their bind.
module mbadu_checker (
  input logic clk,
  input logic rst,
  input logic verdict_valid,
  input logic verdict_ready,
  input logic [1:0] status,
  input logic [7:0] unit_id,
  input logic [15:0] mbap_tid,
  input logic [7:0] payload_len
);

  // A stalled verdict keeps its contents until it is taken.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && !verdict_ready |=> verdict_valid && $stable(status) &&
    $stable(unit_id) && $stable(mbap_tid) && $stable(payload_len))
    else $error("verdict changed while stalled");

  // A rejected frame reports no identifiers and no length.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && status != mbadu_pkg::ST_OK |->
    unit_id == 8'd0 && mbap_tid == 16'd0 && payload_len == 8'd0)
    else $error("error verdict carries nonzero fields");

  // Minimum frame lengths leave at least one PDU byte in an accepted frame.
  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && status == mbadu_pkg::ST_OK |-> payload_len != 8'd0)
    else $error("accepted frame with empty PDU");

  // No verdict is pending right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !verdict_valid)
    else $error("verdict valid after reset");

endmodule

bind modbus_adu_frame_checker mbadu_checker u_mbadu_checker (
  .clk(clk),
  .rst(rst),
  .verdict_valid(verdict.valid),
  .verdict_ready(verdict.ready),
  .status(verdict.status),
  .unit_id(verdict.unit_id),
  .mbap_tid(verdict.mbap_tid),
  .payload_len(verdict.payload_len)
);
